// File: rtl/best_fit_block_allocator_assert.svh
`ifndef BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
// Same-cycle implication on clk_i, held off during reset.
`define BFA_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication on clk_i, held off during reset.
`define BFA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/bfa_pkg.sv
package bfa_pkg;
  localparam int ADDR_BITS = 24;
  localparam int PAGE_BITS = 17;
  localparam int LIMIT_BITS = 25;
  localparam int CFG_BITS = 25;

  localparam logic [0:0] CFG_PAGE_BYTES = 1'b0;
  localparam logic [0:0] CFG_HEAP_LIMIT = 1'b1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NO_HEAP = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic action;
    logic [ADDR_BITS-1:0] request_size;
    logic [ADDR_BITS-1:0] free_address;
  } in_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] data_address;
    status_e status;
  } out_t;
endpackage

// File: rtl/best_fit_block_allocator.sv
// Best-fit heap block allocator. One word in gives one word out. A free scans the block
// table one entry at a time, a memory read and then a compare, and stops at the match.
// An allocate scans the table once in the same way, looking for an exact fit and the best
// split candidate together, and stops at the first exact fit; a split then moves every
// entry above the chosen one up by one slot through the single table memory port, then
// writes the two halves. Heap growth adds a bit-serial remainder unit and a heap check.
// The block takes no new word until the current result has moved into the output
// register.
module best_fit_block_allocator #(
  parameter int MAX_BLOCKS = 64,
  parameter int HEADER_BYTES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bfa_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bfa_pkg::out_t                out_data_o,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [bfa_pkg::CFG_BITS-1:0] cfg_data_i
);
  localparam int AW = bfa_pkg::ADDR_BITS;
  localparam int PW = bfa_pkg::PAGE_BITS;
  localparam int LW = bfa_pkg::LIMIT_BITS;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int NW = AW + 1;
  localparam int DW = $clog2(NW);
  localparam int GW = AW + 2;
  localparam logic [AW:0] HDR = (AW+1)'(HEADER_BYTES);
  localparam logic [CW:0] MAXB = (CW+1)'(MAX_BLOCKS);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SC_RD = 12'b000000000010,
    S_SC_CM = 12'b000000000100,
    S_ST_RD = 12'b000000001000,
    S_ST_GT = 12'b000000010000,
    S_DIV   = 12'b000000100000,
    S_GROW  = 12'b000001000000,
    S_SH_RD = 12'b000010000000,
    S_SH_WR = 12'b000100000000,
    S_W1    = 12'b001000000000,
    S_W2    = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  state_e              state_q;
  bfa_pkg::in_t        in_q;
  logic [CW-1:0]       scan_q, j_q, count_q;
  logic                exact_hit_q, fit_hit_q;
  logic [IW-1:0]       exact_idx_q, fit_idx_q, sp_idx_q;
  logic [AW-1:0]       fit_size_q, sp_start_q, sp_size_q;
  logic [PW-1:0]       rem_q;
  logic [DW-1:0]       div_cnt_q;
  logic [AW:0]         top_q;
  logic [AW-1:0]       res_data_q;
  bfa_pkg::status_e    res_status_q;
  logic                out_valid_q;
  bfa_pkg::out_t       out_q;
  logic [PW-1:0]       page_q;
  logic [LW-1:0]       limit_q;
  logic [MAX_BLOCKS-1:0] busy_q;

  // table memory: one write and one registered read per cycle
  logic [AW-1:0] mem_start [MAX_BLOCKS];
  logic [AW-1:0] mem_size [MAX_BLOCKS];
  logic [AW-1:0] rd_start_q, rd_size_q;
  logic [IW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [AW-1:0] wr_start, wr_size;

  logic          in_fire;
  logic          out_load;
  logic [PW-1:0] page_eff;
  logic [NW-1:0] div_n;
  logic [PW:0]   div_tmp;
  logic [GW-1:0] grow;
  logic [AW:0]   lim_eff;
  logic [CW-1:0] jm1;
  logic [AW:0]   req_hdr;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign page_eff = (page_q == '0) ? PW'(1) : page_q;
  assign div_n = NW'({HDR, 1'b0}) + NW'(in_q.request_size);
  assign div_tmp = {rem_q, div_n[div_cnt_q]};
  assign grow = GW'(div_n) - GW'(rem_q) + GW'(page_eff);
  assign lim_eff = ({1'b0, limit_q} > LW'(1) << AW) ? (AW+1)'(1) << AW : (AW+1)'(limit_q);
  assign jm1 = j_q - CW'(1);
  assign req_hdr = (AW+1)'(in_q.request_size) + HDR;

  always_comb begin
    rd_addr = scan_q[IW-1:0];
    wr_en = 1'b0;
    wr_addr = sp_idx_q;
    wr_start = sp_start_q;
    wr_size = in_q.request_size;
    case (state_q)
      S_ST_RD: rd_addr = exact_hit_q ? exact_idx_q : fit_idx_q;
      S_SH_RD: rd_addr = jm1[IW-1:0];
      S_SH_WR: begin
        wr_en = 1'b1;
        wr_addr = j_q[IW-1:0];
        wr_start = rd_start_q;
        wr_size = rd_size_q;
      end
      S_W1: wr_en = 1'b1;
      S_W2: begin
        wr_en = 1'b1;
        wr_addr = sp_idx_q + IW'(1);
        wr_start = AW'(sp_start_q + HDR[AW-1:0] + in_q.request_size);
        wr_size = AW'(sp_size_q - in_q.request_size - HDR[AW-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_size[wr_addr] <= wr_size;
    end
    rd_start_q <= mem_start[rd_addr];
    rd_size_q <= mem_size[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      in_q <= '0;
      scan_q <= '0;
      j_q <= '0;
      count_q <= '0;
      exact_hit_q <= 1'b0;
      fit_hit_q <= 1'b0;
      exact_idx_q <= '0;
      fit_idx_q <= '0;
      sp_idx_q <= '0;
      fit_size_q <= '0;
      sp_start_q <= '0;
      sp_size_q <= '0;
      rem_q <= '0;
      div_cnt_q <= '0;
      top_q <= '0;
      res_data_q <= '0;
      res_status_q <= bfa_pkg::ST_OK;
      out_valid_q <= 1'b0;
      out_q <= '0;
      page_q <= PW'(4096);
      limit_q <= LW'(1) << AW;
      busy_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bfa_pkg::CFG_PAGE_BYTES) page_q <= cfg_data_i[PW-1:0];
        else limit_q <= cfg_data_i[LW-1:0];
      end
      // load a new result, or drop the old one once taken
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            in_q <= in_data_i;
            scan_q <= '0;
            exact_hit_q <= 1'b0;
            fit_hit_q <= 1'b0;
            res_data_q <= '0;
            res_status_q <= bfa_pkg::ST_OK;
            state_q <= S_SC_RD;
          end
        end
        S_SC_RD: begin
          if (scan_q != count_q) begin
            state_q <= S_SC_CM;
          end else if (in_q.action == bfa_pkg::ACT_FREE) begin
            res_status_q <= bfa_pkg::ST_NOT_FOUND;
            state_q <= S_DONE;
          end else if (fit_hit_q) begin
            // split needs one spare table entry
            if ((CW+1)'(count_q) >= MAXB) begin
              res_status_q <= bfa_pkg::ST_TABLE_FULL;
              state_q <= S_DONE;
            end else begin
              state_q <= S_ST_RD;
            end
          end else if ((CW+1)'(count_q) + (CW+1)'(2) > MAXB) begin
            // growth needs two spare entries
            res_status_q <= bfa_pkg::ST_TABLE_FULL;
            state_q <= S_DONE;
          end else begin
            rem_q <= '0;
            div_cnt_q <= DW'(NW - 1);
            state_q <= S_DIV;
          end
        end
        S_SC_CM: begin
          scan_q <= scan_q + CW'(1);
          if (in_q.action == bfa_pkg::ACT_FREE) begin
            if ((rd_start_q + HDR) == (AW+1)'(in_q.free_address)) begin
              busy_q[scan_q[IW-1:0]] <= 1'b0;
              state_q <= S_DONE;
            end else begin
              state_q <= S_SC_RD;
            end
          end else if (!busy_q[scan_q[IW-1:0]] && rd_size_q == in_q.request_size) begin
            // first exact fit wins outright
            exact_hit_q <= 1'b1;
            exact_idx_q <= scan_q[IW-1:0];
            state_q <= S_ST_RD;
          end else begin
            state_q <= S_SC_RD;
            if (!busy_q[scan_q[IW-1:0]] && req_hdr < (AW+1)'(rd_size_q) &&
                (!fit_hit_q || fit_size_q > rd_size_q)) begin
              fit_hit_q <= 1'b1;
              fit_idx_q <= scan_q[IW-1:0];
              fit_size_q <= rd_size_q;
            end
          end
        end
        S_ST_RD: state_q <= S_ST_GT;
        S_ST_GT: begin
          if (exact_hit_q) begin
            busy_q[exact_idx_q] <= 1'b1;
            res_data_q <= AW'(rd_start_q + HDR[AW-1:0]);
            state_q <= S_DONE;
          end else begin
            sp_idx_q <= fit_idx_q;
            sp_start_q <= rd_start_q;
            sp_size_q <= fit_size_q;
            j_q <= count_q;
            if (count_q > CW'(fit_idx_q) + CW'(1)) state_q <= S_SH_RD;
            else state_q <= S_W1;
          end
        end
        S_DIV: begin
          // one remainder bit per cycle, MSB first
          if (div_tmp >= (PW+1)'(page_eff)) rem_q <= PW'(div_tmp - (PW+1)'(page_eff));
          else rem_q <= div_tmp[PW-1:0];
          div_cnt_q <= div_cnt_q - DW'(1);
          if (div_cnt_q == '0) state_q <= S_GROW;
        end
        S_GROW: begin
          if ((GW+1)'(top_q) + (GW+1)'(grow) > (GW+1)'(lim_eff)) begin
            res_status_q <= bfa_pkg::ST_NO_HEAP;
            state_q <= S_DONE;
          end else begin
            // append the new block, then split it as the last entry
            sp_idx_q <= count_q[IW-1:0];
            sp_start_q <= top_q[AW-1:0];
            sp_size_q <= AW'(grow - GW'(HDR));
            busy_q[count_q[IW-1:0]] <= 1'b0;
            count_q <= count_q + CW'(1);
            top_q <= (AW+1)'(GW'(top_q) + grow);
            state_q <= S_W1;
          end
        end
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: begin
          busy_q[j_q[IW-1:0]] <= busy_q[jm1[IW-1:0]];
          j_q <= jm1;
          if (jm1 > CW'(sp_idx_q) + CW'(1)) state_q <= S_SH_RD;
          else state_q <= S_W1;
        end
        S_W1: begin
          busy_q[sp_idx_q] <= 1'b1;
          state_q <= S_W2;
        end
        S_W2: begin
          busy_q[sp_idx_q + IW'(1)] <= 1'b0;
          count_q <= count_q + CW'(1);
          res_data_q <= AW'(sp_start_q + HDR[AW-1:0]);
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (out_load) begin
            out_q.data_address <= res_data_q;
            out_q.status <= res_status_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "best_fit_block_allocator_assert.svh"
  `BFA_CHECK(a_count_max, 1'b1, (CW+1)'(count_q) <= MAXB, "block count beyond table")
  `BFA_CHECK(a_top_max, 1'b1, top_q <= ((AW+1)'(1) << AW), "heap top beyond address space")
  `BFA_CHECK_NEXT(a_split_count, state_q == S_W2, count_q == $past(count_q) + CW'(1), "split lost entry")
  `BFA_CHECK_NEXT(a_done_out, state_q == S_DONE && (!out_valid_q || out_ready_i), out_valid_q, "result dropped")
endmodule

// File: sim/tb.sv
module tb;
  localparam int HDR         = 32;
  localparam int TABLE_DEPTH = 64;
  localparam int RAND_WORDS  = 600;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 4 * TABLE_DEPTH + 60;
  localparam int AW          = bfa_pkg::ADDR_BITS;
  localparam int CFGW        = bfa_pkg::CFG_BITS;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  bfa_pkg::in_t        in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  bfa_pkg::out_t       out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [0:0]          cfg_idx_i = bfa_pkg::CFG_PAGE_BYTES;
  logic [CFGW-1:0]     cfg_data_i = '0;

  best_fit_block_allocator dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the block table, heap pointer and registers.
  longint unsigned shadow_start [TABLE_DEPTH];
  longint unsigned shadow_size  [TABLE_DEPTH];
  bit              shadow_busy  [TABLE_DEPTH];
  int unsigned     shadow_count;
  longint unsigned shadow_top;
  longint unsigned page_reg;
  longint unsigned limit_reg;

  bfa_pkg::out_t   pending_results [$];
  logic [AW-1:0]   live_blocks [$];
  int              fail_count;
  int              status_seen [4];
  int              words_sent;
  int              idle_cycles;

  // Carve the front req bytes off entry idx as busy; the rest stays free.
  function automatic void split_block(int unsigned idx, longint unsigned req);
    for (int unsigned j = shadow_count; j > idx + 1; j--) begin
      shadow_start[j] = shadow_start[j-1];
      shadow_size[j]  = shadow_size[j-1];
      shadow_busy[j]  = shadow_busy[j-1];
    end
    shadow_start[idx+1] = shadow_start[idx] + HDR + req;
    shadow_size[idx+1]  = shadow_size[idx] - req - HDR;
    shadow_busy[idx+1]  = 1'b0;
    shadow_count++;
    shadow_size[idx] = req;
    shadow_busy[idx] = 1'b1;
  endfunction

  // Predict the answer to one word and advance the shadow heap.
  function automatic bfa_pkg::out_t heap_answer(bfa_pkg::in_t w);
    bfa_pkg::out_t   r;
    longint unsigned req;
    longint unsigned page;
    longint unsigned lim;
    longint unsigned grow;
    int              best;
    int unsigned     idx;
    req = w.request_size;
    r.data_address = '0;
    r.status = bfa_pkg::ST_OK;
    if (w.action == bfa_pkg::ACT_FREE) begin
      for (int unsigned i = 0; i < shadow_count; i++)
        if (shadow_start[i] + HDR == w.free_address) begin
          shadow_busy[i] = 1'b0;
          return r;
        end
      r.status = bfa_pkg::ST_NOT_FOUND;
      return r;
    end
    // Exact fit wins outright.
    for (int unsigned i = 0; i < shadow_count; i++)
      if (!shadow_busy[i] && shadow_size[i] == req) begin
        shadow_busy[i] = 1'b1;
        r.data_address = AW'(shadow_start[i] + HDR);
        return r;
      end
    // Smallest block with room for a header to spare, earliest on a tie.
    best = -1;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (shadow_busy[i] || req + HDR >= shadow_size[i]) continue;
      if (best < 0 || shadow_size[best] > shadow_size[i]) best = i;
    end
    if (best >= 0) begin
      if (shadow_count >= TABLE_DEPTH) begin
        r.status = bfa_pkg::ST_TABLE_FULL;
        return r;
      end
      split_block(best, req);
      r.data_address = AW'(shadow_start[best] + HDR);
      return r;
    end
    // Grow the heap by whole pages.
    page = (page_reg == 0) ? 1 : page_reg;
    lim  = (limit_reg > (64'd1 << AW)) ? (64'd1 << AW) : limit_reg;
    if (shadow_count + 2 > TABLE_DEPTH) begin
      r.status = bfa_pkg::ST_TABLE_FULL;
      return r;
    end
    grow = ((2 * HDR + req) / page + 1) * page;
    if (shadow_top + grow > lim) begin
      r.status = bfa_pkg::ST_NO_HEAP;
      return r;
    end
    idx = shadow_count;
    shadow_start[idx] = shadow_top;
    shadow_size[idx]  = grow - HDR;
    shadow_busy[idx]  = 1'b0;
    shadow_count++;
    shadow_top += grow;
    split_block(idx, req);
    r.data_address = AW'(shadow_start[idx] + HDR);
    return r;
  endfunction

  // Directed words; typed answers only where they follow from reset at a glance.
  typedef struct {
    logic                 act;
    logic [AW-1:0]        size;
    logic [AW-1:0]        addr;
    bit                   typed;
    logic [AW-1:0]        want_addr;
    bfa_pkg::status_e     want_status;
  } probe_t;

  probe_t probes [] = '{
    '{bfa_pkg::ACT_FREE,  24'd0,        24'd0,      1, 24'd0,    bfa_pkg::ST_NOT_FOUND},
    '{bfa_pkg::ACT_ALLOC, 24'd0,        24'hFFFFFF, 1, 24'd32,   bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_ALLOC, 24'd100,      24'h0,      1, 24'd64,   bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_FREE,  24'hFFFFFF,   24'd32,     1, 24'd0,    bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_FREE,  24'd0,        24'd32,     1, 24'd0,    bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_ALLOC, 24'd0,        24'd0,      1, 24'd32,   bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_ALLOC, 24'hFFFFFF,   24'd0,      1, 24'd0,    bfa_pkg::ST_NO_HEAP},
    '{bfa_pkg::ACT_FREE,  24'd0,        24'hFFFFFF, 1, 24'd0,    bfa_pkg::ST_NOT_FOUND},
    '{bfa_pkg::ACT_ALLOC, 24'd3900,     24'd0,      1, 24'd196,  bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_ALLOC, 24'd5000,     24'd0,      1, 24'd4128, bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_FREE,  24'd0,        24'd9160,   1, 24'd0,    bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_ALLOC, 24'd3000,     24'd0,      0, 24'd0,    bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_ALLOC, 24'd4000,     24'd0,      0, 24'd0,    bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_FREE,  24'd0,        24'd64,     0, 24'd0,    bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_ALLOC, 24'd50,       24'd0,      0, 24'd0,    bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_ALLOC, 24'd16777100, 24'd0,      0, 24'd0,    bfa_pkg::ST_OK},
    '{bfa_pkg::ACT_FREE,  24'hAAAAAA,   24'h555555, 0, 24'd0,    bfa_pkg::ST_OK}
  };

  // Register settings per random phase: {page_bytes, heap_limit}.
  longint unsigned phase_cfg [][2] = '{
    '{0,      33554431},
    '{65536,  16777216},
    '{131071, 0},
    '{1,      5000000},
    '{64,     1 << 20}
  };

  // Length of an idle gap: mostly none or short, a few long.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    else if (r < 95) return $urandom_range(3, 1);
    else return $urandom_range(60, 20);
  endfunction

  // Hold the word until the block takes it, then record the expectation.
  task automatic send_word(bfa_pkg::in_t w, bit typed, bfa_pkg::out_t want);
    bfa_pkg::out_t predicted;
    int            gap;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = heap_answer(w);
    pending_results.push_back(typed ? want : predicted);
    if (w.action == bfa_pkg::ACT_ALLOC && predicted.status == bfa_pkg::ST_OK)
      live_blocks.push_back(predicted.data_address);
    words_sent++;
    gap = $urandom_range(1) ? gap_cycles() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [0:0] idx, longint unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFGW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == bfa_pkg::CFG_PAGE_BYTES) page_reg = value & 17'h1FFFF;
    else limit_reg = value & 25'h1FFFFFF;
  endtask

  // Drain: drop valid and hold until every expected word has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Receiver: random back-pressure, compare each word with the oldest expectation.
  int stall_left;
  always @(posedge clk_i) begin
    bfa_pkg::out_t want;
    if (out_valid_o && out_ready_i) begin
      idle_cycles <= 0;
      if (pending_results.size() == 0) begin
        $error("unexpected word data_address=%0h status=%0d",
               out_data_o.data_address, out_data_o.status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        status_seen[out_data_o.status]++;
        if (out_data_o.data_address !== want.data_address) begin
          $error("data_address expected %0h got %0h",
                 want.data_address, out_data_o.data_address);
          fail_count++;
        end
        if (out_data_o.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_data_o.status);
          fail_count++;
        end
      end
    end else if (in_valid_i && in_ready_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(99) < 8) begin
      stall_left <= ($urandom_range(19) == 0) ? $urandom_range(60, 20)
                                               : $urandom_range(3, 1);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk_i)
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end

  initial begin
    bfa_pkg::in_t  w;
    bfa_pkg::out_t want;
    int            pick;
    fail_count = 0;
    words_sent = 0;
    idle_cycles = 0;
    stall_left = 0;
    shadow_count = 0;
    shadow_top = 0;
    page_reg = 4096;
    limit_reg = 16777216;
    foreach (shadow_busy[i]) shadow_busy[i] = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset register values.
    foreach (probes[k]) begin
      w.action = probes[k].act;
      w.request_size = probes[k].size;
      w.free_address = probes[k].addr;
      want.data_address = probes[k].want_addr;
      want.status = probes[k].want_status;
      send_word(w, probes[k].typed, want);
    end

    // Random phases, each behind a full drain so registers change while idle.
    foreach (phase_cfg[p]) begin
      drain();
      write_reg(bfa_pkg::CFG_PAGE_BYTES, phase_cfg[p][0]);
      write_reg(bfa_pkg::CFG_HEAP_LIMIT, phase_cfg[p][1]);
      repeat (RAND_WORDS / phase_cfg.size()) begin
        w.request_size = AW'($urandom);
        w.free_address = AW'($urandom);
        pick = $urandom_range(99);
        if (pick < 45) begin
          // Reuse a few sizes so freed blocks get exact fits.
          w.action = bfa_pkg::ACT_ALLOC;
          if (pick < 30) w.request_size = AW'(16 * $urandom_range(7));
          else if (pick < 42) w.request_size = AW'($urandom_range(5000));
        end else if (pick < 90 && live_blocks.size() != 0) begin
          w.action = bfa_pkg::ACT_FREE;
          w.free_address = live_blocks[$urandom_range(live_blocks.size() - 1)];
        end else begin
          w.action = 1'($urandom_range(1));
        end
        send_word(w, 1'b0, want);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("sent %0d words over %0d register settings, table ended with %0d blocks",
             words_sent, phase_cfg.size() + 1, shadow_count);
    $display("answers: ok %0d, out of heap %0d, table full %0d, not found %0d",
             status_seen[bfa_pkg::ST_OK], status_seen[bfa_pkg::ST_NO_HEAP],
             status_seen[bfa_pkg::ST_TABLE_FULL], status_seen[bfa_pkg::ST_NOT_FOUND]);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
